@@ design/dsr_pkg.sv @@
package dsr_pkg;

  // Port and field widths
  localparam int CFG_W = 32;
  localparam int IDX_W = 3;
  localparam int TAU_W = 32;
  localparam int P_W   = 17;
  localparam int EFF_W = 32;
  localparam int V_W   = 16;
  localparam int Q_W   = 32;
  localparam int OUT_W = 32;

  // Datapath widths
  localparam int MUL_W  = 34;
  localparam int ACC_W  = 2 * MUL_W;
  localparam int DIV_W  = 50;
  localparam int DCNT_W = $clog2(DIV_W);

  localparam logic [TAU_W-1:0] TAU_REC_RST = 32'd52428800;
  localparam logic [TAU_W-1:0] TAU_INA_RST = 32'd196608;
  localparam logic [TAU_W-1:0] TAU_FAC_RST = 32'd3276800;
  localparam logic [P_W-1:0]   REL_P_RST   = 17'd43909;
  localparam logic [EFF_W-1:0] EFF_RST     = 32'd16384000;
  localparam logic [P_W-1:0]   P_ONE       = 17'h10000;

  localparam logic [TAU_W-1:0]        STEP_DIV  = 32'd1000;
  localparam logic [TAU_W-1:0]        STEP_DIV2 = 32'd2000;
  localparam logic signed [MUL_W-1:0] Q30_ONE  = 34'sd1073741824;
  localparam logic signed [ACC_W-1:0] RND_27   = ACC_W'(64'sd134217728);
  localparam logic signed [ACC_W-1:0] RND_29   = ACC_W'(64'sd536870912);
  localparam logic signed [ACC_W-1:0] S32_MAX  = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] S32_MIN  = ACC_W'(-64'sd2147483648);

  // Divide by 1000: magnitudes clip at 1000 * 2^31 (slope saturates there),
  // estimate from (m >> 8) * floor(2^42 / 1000) >> 34, then at most two fixups.
  localparam int                  KQ_W  = 41;
  localparam logic [KQ_W-1:0]     K_SAT = 41'd2147483648000;
  localparam logic [MUL_W-2:0]    K_RCP = 33'd4398046511;
  localparam int                  K_SH  = 34;

  typedef enum logic [IDX_W-1:0] {
    REG_TAU_REC = 3'd0,
    REG_TAU_INA = 3'd1,
    REG_TAU_FAC = 3'd2,
    REG_REL_P   = 3'd3,
    REG_EFF     = 3'd4
  } reg_idx_e;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_UX    = 15'b000000000000010,
    S_PU    = 15'b000000000000100,
    S_PUL   = 15'b000000000001000,
    S_DLOAD = 15'b000000000010000,
    S_DIVT  = 15'b000000000100000,
    S_DADD  = 15'b000000001000000,
    S_DIVK  = 15'b000000010000000,
    S_DFIX  = 15'b000000100000000,
    S_SLOPE = 15'b000001000000000,
    S_MACM  = 15'b000010000000000,
    S_MACA  = 15'b000100000000000,
    S_UPD   = 15'b001000000000000,
    S_OMUL  = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_e;

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > S32_MAX) r = 32'sh7fffffff;
    else if (v < S32_MIN) r = 32'sh80000000;
    else r = v[Q_W-1:0];
    return r;
  endfunction

  // Tableau weights, Q4.28. Rows 0..4 build the stage values, row 5 is the
  // final combination.
  function automatic logic signed [31:0] rk_weight(input logic [2:0] st,
                                                   input logic [2:0] m);
    logic signed [31:0] w;
    case ({st, m})
      6'o00: w = 32'sd53687091;
      6'o10: w = 32'sd20132659;
      6'o11: w = 32'sd60397978;
      6'o20: w = 32'sd80530637;
      6'o21: w = -32'sd241591910;
      6'o22: w = 32'sd322122547;
      6'o30: w = 32'sd20132659;
      6'o31: w = 32'sd181193933;
      6'o32: w = -32'sd161061274;
      6'o33: w = 32'sd201326592;
      6'o40: w = 32'sd177299962;
      6'o41: w = 32'sd671088640;
      6'o42: w = -32'sd1391887550;
      6'o43: w = 32'sd1043915662;
      6'o44: w = -32'sd231981258;
      6'o50: w = 32'sd26512144;
      6'o52: w = 32'sd106522006;
      6'o53: w = 32'sd62137837;
      6'o54: w = 32'sd82850449;
      6'o55: w = -32'sd9586981;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

@@ design/dsr_if.sv @@
interface dsr_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [dsr_pkg::V_W-1:0]    presyn_voltage;
  modport source (output valid, output presyn_voltage, input ready);
  modport sink   (input valid, input presyn_voltage, output ready);
endinterface

interface dsr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dsr_pkg::OUT_W-1:0]  syn_current;
  modport source (output valid, output syn_current, input ready);
  modport sink   (input valid, input syn_current, output ready);
endinterface

@@ design/dynamic_synapse_rk6_step.sv @@
// Each beat runs through the same sequence of states from accept to result, for every input.
// One beat at a time: no new beat is taken until the last is through. The shared
//   restoring divider for the time constants (18 divisions per step) sets most of
//   the run time, the shared multiplier (stage sums, drive terms, divide by 1000) the rest.
// A finished result sits in the output register; the next beat is taken meanwhile.
// Reset (rst_ni low, async): state variables clear to zero, registers take their
//   default values, the sequencer returns to idle and the output holds no beat.
module dynamic_synapse_rk6_step (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dsr_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [dsr_pkg::CFG_W-1:0]    cfg_data_i,
  dsr_in_if.sink                       in_i,
  dsr_out_if.source                    out_o
);

  // ---------------------------------------------------------------- registers
  logic [dsr_pkg::TAU_W-1:0] tau_rec_q, tau_ina_q, tau_fac_q;
  logic [dsr_pkg::P_W-1:0]   rel_p_q;
  logic [dsr_pkg::EFF_W-1:0] eff_q;

  // base: state at step start (x, y, u); cur: stage value being evaluated
  logic signed [dsr_pkg::Q_W-1:0] base_q [3];
  logic signed [dsr_pkg::Q_W-1:0] cur_q  [3];
  logic signed [dsr_pkg::Q_W-1:0] slope_q [6][3];

  dsr_pkg::state_e state_q, state_d;
  logic [2:0] st_q;   // RK stage 0..5
  logic [1:0] c_q;    // variable 0..2
  logic [2:0] m_q;    // tableau term
  logic       drive_q;

  // shared multiplier
  logic                              mul_en;
  logic signed [dsr_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [dsr_pkg::ACC_W-1:0]  mul_q;
  logic signed [dsr_pkg::ACC_W-1:0]  acc_q;
  logic signed [dsr_pkg::MUL_W-1:0]  ux_q, pu_q;

  // shared divider, magnitude restoring, one quotient bit per cycle
  logic [dsr_pkg::TAU_W-1:0]  div_rem_q, div_den_q;
  logic [dsr_pkg::DIV_W-1:0]  div_quo_q;
  logic [dsr_pkg::DCNT_W-1:0] div_cnt_q;
  logic                       div_neg_q;

  logic                              out_valid_q;
  logic signed [dsr_pkg::OUT_W-1:0]  out_data_q;

  // ---------------------------------------------------------------- datapath
  logic signed [dsr_pkg::MUL_W-1:0]  num_s, num_abs;
  logic [dsr_pkg::DIV_W-1:0]         num_mag;
  logic [dsr_pkg::TAU_W-1:0]         tau_sel, den_tau;
  logic [dsr_pkg::TAU_W:0]           div_shift;
  logic [dsr_pkg::TAU_W+1:0]         div_diff;
  logic                              div_ok;
  logic                              div_last;
  logic signed [dsr_pkg::DIV_W:0]    div_qs;
  logic signed [dsr_pkg::DIV_W+1:0]  der_s, der_abs, der_add;
  logic [dsr_pkg::KQ_W-1:0]          kq_mc;
  logic [dsr_pkg::MUL_W-2:0]         kq_est, kq_fix;
  logic [dsr_pkg::KQ_W+1:0]          kq_rem;
  logic signed [dsr_pkg::ACC_W-1:0]  mul_sh30, mul_sh16, acc_rnd, upd_sum, out_rnd;
  logic signed [dsr_pkg::Q_W-1:0]    upd_val, slope_val, out_val;
  logic [2:0]                        m_last;

  always_comb begin
    // derivative numerators
    case (c_q)
      2'd0: begin
        num_s   = dsr_pkg::Q30_ONE - dsr_pkg::MUL_W'(cur_q[0]) - dsr_pkg::MUL_W'(cur_q[1]);
        tau_sel = tau_rec_q;
      end
      2'd1: begin
        num_s   = -dsr_pkg::MUL_W'(cur_q[1]);
        tau_sel = tau_ina_q;
      end
      default: begin
        num_s   = dsr_pkg::MUL_W'($signed({1'b0, rel_p_q, 14'b0}))
                  - dsr_pkg::MUL_W'(cur_q[2]);
        tau_sel = tau_fac_q;
      end
    endcase
    num_abs = num_s[dsr_pkg::MUL_W-1] ? -num_s : num_s;
    num_mag = {num_abs[dsr_pkg::DIV_W-17:0], 16'b0};
    den_tau = (tau_sel == '0) ? dsr_pkg::TAU_W'(1) : tau_sel;

    div_shift = {div_rem_q, div_quo_q[dsr_pkg::DIV_W-1]};
    div_diff  = {1'b0, div_shift} - {2'b0, div_den_q};
    div_ok    = !div_diff[dsr_pkg::TAU_W+1];
    div_last  = (div_cnt_q == dsr_pkg::DCNT_W'(dsr_pkg::DIV_W - 1));
    div_qs    = div_neg_q ? -$signed({1'b0, div_quo_q}) : $signed({1'b0, div_quo_q});

    // drive terms: -ux on x, +ux on y, p*(1-u) on u
    case (c_q)
      2'd0:    der_add = -(dsr_pkg::DIV_W+2)'(ux_q);
      2'd1:    der_add = (dsr_pkg::DIV_W+2)'(ux_q);
      default: der_add = (dsr_pkg::DIV_W+2)'(pu_q);
    endcase
    der_s   = (dsr_pkg::DIV_W+2)'(div_qs) + (drive_q ? der_add : '0);
    der_abs = der_s[dsr_pkg::DIV_W+1] ? -der_s : der_s;

    // divide by 1000: clip (slope saturates beyond), reciprocal estimate,
    // remainder by shifts, then up to two corrections
    kq_mc  = (der_abs > $signed({11'b0, dsr_pkg::K_SAT})) ? dsr_pkg::K_SAT
                                                          : der_abs[dsr_pkg::KQ_W-1:0];
    kq_est = mul_q[dsr_pkg::K_SH+dsr_pkg::MUL_W-2:dsr_pkg::K_SH];
    kq_rem = {2'b0, div_quo_q[dsr_pkg::KQ_W-1:0]} - {kq_est, 10'b0}
             + {6'b0, kq_est, 4'b0} + {7'b0, kq_est, 3'b0};
    if (kq_rem >= {11'b0, dsr_pkg::STEP_DIV2})     kq_fix = kq_est + 33'd2;
    else if (kq_rem >= {11'b0, dsr_pkg::STEP_DIV}) kq_fix = kq_est + 33'd1;
    else                                            kq_fix = kq_est;

    slope_val = dsr_pkg::sat32(dsr_pkg::ACC_W'(div_qs));

    mul_sh30 = mul_q >>> 30;
    mul_sh16 = mul_q >>> 16;
    acc_rnd  = (acc_q + dsr_pkg::RND_27) >>> 28;
    upd_sum  = acc_rnd + dsr_pkg::ACC_W'(base_q[c_q]);
    upd_val  = dsr_pkg::sat32(upd_sum);
    out_rnd  = (mul_q + dsr_pkg::RND_29) >>> 30;
    out_val  = dsr_pkg::sat32(out_rnd);

    m_last = (st_q == 3'd5) ? 3'd5 : st_q;

    // multiplier operand select
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      dsr_pkg::S_UX: begin
        mul_a = dsr_pkg::MUL_W'(cur_q[2]);
        mul_b = dsr_pkg::MUL_W'(cur_q[0]);
      end
      dsr_pkg::S_PU: begin
        mul_a = $signed({{(dsr_pkg::MUL_W-dsr_pkg::P_W){1'b0}}, rel_p_q});
        mul_b = dsr_pkg::Q30_ONE - dsr_pkg::MUL_W'(cur_q[2]);
      end
      dsr_pkg::S_DIVK: begin
        mul_a = $signed({1'b0, div_quo_q[dsr_pkg::KQ_W-1:8]});
        mul_b = $signed({1'b0, dsr_pkg::K_RCP});
      end
      dsr_pkg::S_MACM: begin
        mul_a = dsr_pkg::MUL_W'(dsr_pkg::rk_weight(st_q, m_q));
        mul_b = dsr_pkg::MUL_W'(slope_q[m_q][c_q]);
      end
      dsr_pkg::S_OMUL: begin
        mul_a = $signed({2'b0, eff_q});
        mul_b = dsr_pkg::MUL_W'(cur_q[1]);
      end
      default: mul_en = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dsr_pkg::S_IDLE:  if (in_i.valid) state_d = dsr_pkg::S_UX;
      dsr_pkg::S_UX:    state_d = dsr_pkg::S_PU;
      dsr_pkg::S_PU:    state_d = dsr_pkg::S_PUL;
      dsr_pkg::S_PUL:   state_d = dsr_pkg::S_DLOAD;
      dsr_pkg::S_DLOAD: state_d = dsr_pkg::S_DIVT;
      dsr_pkg::S_DIVT:  if (div_last) state_d = dsr_pkg::S_DADD;
      dsr_pkg::S_DADD:  state_d = dsr_pkg::S_DIVK;
      dsr_pkg::S_DIVK:  state_d = dsr_pkg::S_DFIX;
      dsr_pkg::S_DFIX:  state_d = dsr_pkg::S_SLOPE;
      dsr_pkg::S_SLOPE: state_d = (c_q == 2'd2) ? dsr_pkg::S_MACM : dsr_pkg::S_DLOAD;
      dsr_pkg::S_MACM:  state_d = dsr_pkg::S_MACA;
      dsr_pkg::S_MACA:  state_d = (m_q == m_last) ? dsr_pkg::S_UPD : dsr_pkg::S_MACM;
      dsr_pkg::S_UPD: begin
        if (c_q != 2'd2) state_d = dsr_pkg::S_MACM;
        else if (st_q == 3'd5) state_d = dsr_pkg::S_OMUL;
        else state_d = dsr_pkg::S_UX;
      end
      dsr_pkg::S_OMUL:  state_d = dsr_pkg::S_OUT;
      dsr_pkg::S_OUT:   if (!out_valid_q) state_d = dsr_pkg::S_IDLE;
      default:          state_d = dsr_pkg::S_IDLE;
    endcase
  end

  // control, config and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsr_pkg::S_IDLE;
      st_q        <= '0;
      c_q         <= '0;
      m_q         <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      tau_rec_q   <= dsr_pkg::TAU_REC_RST;
      tau_ina_q   <= dsr_pkg::TAU_INA_RST;
      tau_fac_q   <= dsr_pkg::TAU_FAC_RST;
      rel_p_q     <= dsr_pkg::REL_P_RST;
      eff_q       <= dsr_pkg::EFF_RST;
      for (int i = 0; i < 3; i++) base_q[i] <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          dsr_pkg::REG_TAU_REC: tau_rec_q <= cfg_data_i;
          dsr_pkg::REG_TAU_INA: tau_ina_q <= cfg_data_i;
          dsr_pkg::REG_TAU_FAC: tau_fac_q <= cfg_data_i;
          dsr_pkg::REG_REL_P: begin
            // clamp above one
            rel_p_q <= (cfg_data_i[dsr_pkg::P_W-1:0] > dsr_pkg::P_ONE) ?
                       dsr_pkg::P_ONE : cfg_data_i[dsr_pkg::P_W-1:0];
          end
          dsr_pkg::REG_EFF:     eff_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_o.ready && out_valid_q) out_valid_q <= 1'b0;

      unique case (state_q)
        dsr_pkg::S_IDLE: if (in_i.valid) begin
          st_q <= '0;
          c_q  <= '0;
        end
        dsr_pkg::S_DLOAD: div_cnt_q <= '0;
        dsr_pkg::S_DIVT:  div_cnt_q <= div_cnt_q + 1'b1;
        dsr_pkg::S_SLOPE: begin
          c_q <= (c_q == 2'd2) ? 2'd0 : c_q + 1'b1;
          m_q <= '0;
        end
        dsr_pkg::S_MACA: m_q <= m_q + 1'b1;
        dsr_pkg::S_UPD: begin
          m_q <= '0;
          if (c_q == 2'd2) begin
            c_q <= '0;
            if (st_q == 3'd5) begin
              // commit new state
              base_q[0] <= cur_q[0];
              base_q[1] <= cur_q[1];
              base_q[2] <= upd_val;
            end else begin
              st_q <= st_q + 1'b1;
            end
          end else begin
            c_q <= c_q + 1'b1;
          end
        end
        dsr_pkg::S_OUT: if (!out_valid_q) out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (mul_en) mul_q <= mul_a * mul_b;

    unique case (state_q)
      dsr_pkg::S_IDLE: if (in_i.valid) begin
        drive_q <= (in_i.presyn_voltage > 16'sd0);
        for (int i = 0; i < 3; i++) cur_q[i] <= base_q[i];
      end
      dsr_pkg::S_PU:  ux_q <= mul_sh30[dsr_pkg::MUL_W-1:0];
      dsr_pkg::S_PUL: pu_q <= mul_sh16[dsr_pkg::MUL_W-1:0];
      dsr_pkg::S_DLOAD: begin
        div_rem_q <= '0;
        div_quo_q <= num_mag;
        div_den_q <= den_tau;
        div_neg_q <= num_s[dsr_pkg::MUL_W-1];
      end
      dsr_pkg::S_DADD: begin
        div_quo_q <= {{(dsr_pkg::DIV_W-dsr_pkg::KQ_W){1'b0}}, kq_mc};
        div_neg_q <= der_s[dsr_pkg::DIV_W+1];
      end
      dsr_pkg::S_DIVT: begin
        div_rem_q <= div_ok ? div_diff[dsr_pkg::TAU_W-1:0] : div_shift[dsr_pkg::TAU_W-1:0];
        div_quo_q <= {div_quo_q[dsr_pkg::DIV_W-2:0], div_ok};
      end
      dsr_pkg::S_DFIX:
        div_quo_q <= {{(dsr_pkg::DIV_W-dsr_pkg::MUL_W+1){1'b0}}, kq_fix};
      dsr_pkg::S_SLOPE: begin
        slope_q[st_q][c_q] <= slope_val;
        acc_q <= '0;
      end
      dsr_pkg::S_MACA: acc_q <= acc_q + mul_q;
      dsr_pkg::S_UPD: begin
        cur_q[c_q] <= upd_val;
        acc_q      <= '0;
      end
      dsr_pkg::S_OUT: if (!out_valid_q) out_data_q <= out_val;
      default: ;
    endcase
  end

  assign in_i.ready        = (state_q == dsr_pkg::S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.syn_current = out_data_q;

  // ---------------------------------------------------------------- checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == dsr_pkg::S_OUT))
    else $error("result raised outside output state");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dsr_pkg::S_DIVT) |->
      (div_cnt_q < dsr_pkg::DCNT_W'(dsr_pkg::DIV_W)))
    else $error("divider overran");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q <= 3'd5) && (c_q <= 2'd2) && (m_q <= 3'd6))
    else $error("sequencer index out of range");

  a_mac_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dsr_pkg::S_UPD) |-> $past(state_q == dsr_pkg::S_MACA))
    else $error("update without accumulation");

endmodule

@@ dv/tb_dynamic_synapse_rk6_step.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the fixed-point RK6 dynamic synapse step.
// Beats go in on in_if, currents come back on out_if; every accepted input beat
// runs through a local model of the step and queues the expected current.
module tb_dynamic_synapse_rk6_step;

  typedef longint trio_t [3];

  typedef enum logic [1:0] {
    ROW_BEAT,   // send one voltage beat
    ROW_CFG     // drain, then write one register
  } row_kind_e;

  typedef struct {
    row_kind_e                  kind;
    logic [dsr_pkg::IDX_W-1:0]  idx;
    logic [dsr_pkg::CFG_W-1:0]  data;
    logic [dsr_pkg::V_W-1:0]    volt;
    bit                         fixed;   // expected current typed in below
    logic [dsr_pkg::OUT_W-1:0]  current;
  } stim_row_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int RAND_PHASES    = 8;
  localparam int BEATS_PER_PH   = 160;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [dsr_pkg::IDX_W-1:0] cfg_idx_i;
  logic [dsr_pkg::CFG_W-1:0] cfg_data_i;

  dsr_in_if  in_if ();
  dsr_out_if out_if ();

  dynamic_synapse_rk6_step uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  // Tableau, Q4.28: stage rows, then the final combination
  longint stage_wt [5][5] = '{
    '{53687091, 0, 0, 0, 0},
    '{20132659, 60397978, 0, 0, 0},
    '{80530637, -241591910, 322122547, 0, 0},
    '{20132659, 181193933, -161061274, 201326592, 0},
    '{177299962, 671088640, -1391887550, 1043915662, -231981258}
  };
  longint final_wt [6] = '{26512144, 0, 106522006, 62137837, 82850449, -9586981};

  // Local copy of registers and synapse state
  logic [31:0] m_tau_rec, m_tau_ina, m_tau_fac, m_eff;
  logic [16:0] m_rel_p;
  longint      m_x, m_y, m_u;

  logic [dsr_pkg::OUT_W-1:0] current_q [$];  // expected currents, oldest first
  bit  fail;
  int  send_idle_pct, recv_stall_pct;
  int  quiet_cycles;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint div_tau(longint num, logic [31:0] tau);
    longint d;
    d = (tau == 0) ? 64'sd1 : longint'({32'b0, tau});
    return (num * 65536) / d;
  endfunction

  function automatic trio_t derivs(trio_t s, bit drive);
    trio_t  d;
    longint p, ux;
    p = longint'({47'b0, m_rel_p});
    d[0] = div_tau((64'sd1 <<< 30) - s[0] - s[1], m_tau_rec);
    d[1] = div_tau(-s[1], m_tau_ina);
    d[2] = div_tau(p * 16384 - s[2], m_tau_fac);
    if (drive) begin
      ux = (s[2] * s[0]) >>> 30;
      d[0] -= ux;
      d[1] += ux;
      d[2] += (p * ((64'sd1 <<< 30) - s[2])) >>> 16;
    end
    return d;
  endfunction

  // One integration step; returns the saturated output current
  function automatic logic [dsr_pkg::OUT_W-1:0] synapse_step(logic [dsr_pkg::V_W-1:0] volt);
    bit     drive;
    trio_t  base, cur, d;
    longint slope [6][3];
    longint acc;
    drive = !volt[dsr_pkg::V_W-1] && (volt != 0);
    base = '{m_x, m_y, m_u};
    cur = base;
    for (int st = 0; st < 6; st++) begin
      d = derivs(cur, drive);
      for (int c = 0; c < 3; c++) slope[st][c] = clip32(d[c] / 1000);
      if (st < 5) begin
        for (int c = 0; c < 3; c++) begin
          acc = 0;
          for (int k = 0; k <= st; k++) acc += stage_wt[st][k] * slope[k][c];
          cur[c] = clip32(base[c] + ((acc + (64'sd1 <<< 27)) >>> 28));
        end
      end
    end
    for (int c = 0; c < 3; c++) begin
      acc = 0;
      for (int k = 0; k < 6; k++) acc += final_wt[k] * slope[k][c];
      cur[c] = clip32(base[c] + ((acc + (64'sd1 <<< 27)) >>> 28));
    end
    m_x = cur[0];
    m_y = cur[1];
    m_u = cur[2];
    acc = longint'({32'b0, m_eff}) * m_y;
    return clip32((acc + (64'sd1 <<< 29)) >>> 30);
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: random stall on ready, checks each result beat against the queue
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      if (current_q.size() == 0) begin
        $display("%0t: unexpected current beat, expected none, actual %0d",
                 $time, $signed(out_if.syn_current));
        fail = 1'b1;
      end else begin
        if (out_if.syn_current !== current_q[0]) begin
          $display("%0t: syn_current mismatch, expected %0d, actual %0d", $time,
                   $signed(current_q[0]), $signed(out_if.syn_current));
          fail = 1'b1;
        end
        void'(current_q.pop_front());
      end
    end
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: any cycle without a beat on either side counts toward the limit
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d beats outstanding", $time,
                 current_q.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Send one voltage beat with random idle gaps in front; valid stays high
  // on return so back-to-back beats need no second assignment in one step.
  task automatic send_beat(logic [dsr_pkg::V_W-1:0] volt, bit fixed,
                           logic [dsr_pkg::OUT_W-1:0] current);
    logic [dsr_pkg::OUT_W-1:0] want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      in_if.presyn_voltage <= dsr_pkg::V_W'($urandom);
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.presyn_voltage <= volt;
    do @(posedge clk_i); while (!in_if.ready);
    want = synapse_step(volt);
    if (fixed && want !== current) begin
      $display("%0t: model disagrees with table row, expected %0d, actual %0d",
               $time, $signed(current), $signed(want));
      fail = 1'b1;
    end
    current_q.push_back(fixed ? current : want);
  endtask

  // Block idle: input lowered, all results back, then a short settle
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (current_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [dsr_pkg::IDX_W-1:0] idx, logic [dsr_pkg::CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      dsr_pkg::REG_TAU_REC: m_tau_rec = data;
      dsr_pkg::REG_TAU_INA: m_tau_ina = data;
      dsr_pkg::REG_TAU_FAC: m_tau_fac = data;
      dsr_pkg::REG_REL_P:
        m_rel_p = (data[16:0] > dsr_pkg::P_ONE) ? dsr_pkg::P_ONE : data[16:0];
      dsr_pkg::REG_EFF:     m_eff = data;
      default: ;   // unmapped index, dropped by the block
    endcase
  endtask

  function automatic logic [31:0] pick_tau();
    case ($urandom_range(9))
      0: return 32'd1;
      1: return 32'hFFFF_FFFF;
      2: return 32'd0;
      default: return $urandom_range(32'd65536, 32'd65536 * 1000);
    endcase
  endfunction

  function automatic logic [dsr_pkg::V_W-1:0] pick_volt();
    case ($urandom_range(9))
      0, 1, 2: return '0;
      3, 4:    return dsr_pkg::V_W'($urandom_range(1, 200));
      default: return dsr_pkg::V_W'($urandom);
    endcase
  endfunction

  stim_row_t dir_rows [$];

  initial begin
    int phase;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.presyn_voltage = '0;
    out_if.ready = 1'b0;
    fail = 1'b0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    m_tau_rec = dsr_pkg::TAU_REC_RST;
    m_tau_ina = dsr_pkg::TAU_INA_RST;
    m_tau_fac = dsr_pkg::TAU_FAC_RST;
    m_rel_p = dsr_pkg::REL_P_RST;
    m_eff = dsr_pkg::EFF_RST;
    m_x = 0;
    m_y = 0;
    m_u = 0;

    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. From reset the active fraction is zero and nothing drives
    // it while the voltage is not positive, so those currents read zero, as
    // does any beat while efficacy is zero.
    dir_rows = '{
      '{ROW_BEAT, dsr_pkg::REG_TAU_REC, 0, 16'h0000, 1, 0},
      '{ROW_BEAT, dsr_pkg::REG_TAU_REC, 0, 16'h8000, 1, 0},
      '{ROW_BEAT, dsr_pkg::REG_TAU_REC, 0, 16'hFFFF, 1, 0},
      '{ROW_BEAT, dsr_pkg::REG_TAU_REC, 0, 16'h7FFF, 0, 0},
      '{ROW_BEAT, dsr_pkg::REG_TAU_REC, 0, 16'h0001, 0, 0},
      '{ROW_BEAT, dsr_pkg::REG_TAU_REC, 0, 16'h0000, 0, 0},
      '{ROW_CFG,  dsr_pkg::REG_EFF, 32'd0, 0, 0, 0},
      '{ROW_BEAT, dsr_pkg::REG_TAU_REC, 0, 16'h7FFF, 1, 0},
      '{ROW_CFG,  dsr_pkg::REG_EFF, 32'hFFFF_FFFF, 0, 0, 0},
      '{ROW_BEAT, dsr_pkg::REG_TAU_REC, 0, 16'd100, 0, 0},
      // zero time constants act as the smallest one
      '{ROW_CFG,  dsr_pkg::REG_TAU_REC, 32'd0, 0, 0, 0},
      '{ROW_CFG,  dsr_pkg::REG_TAU_INA, 32'd0, 0, 0, 0},
      '{ROW_CFG,  dsr_pkg::REG_TAU_FAC, 32'd0, 0, 0, 0},
      '{ROW_BEAT, dsr_pkg::REG_TAU_REC, 0, 16'd5, 0, 0},
      '{ROW_BEAT, dsr_pkg::REG_TAU_REC, 0, 16'hFFFB, 0, 0},
      // release probability above one clamps
      '{ROW_CFG,  dsr_pkg::REG_REL_P, 32'h1FFFF, 0, 0, 0},
      '{ROW_BEAT, dsr_pkg::REG_TAU_REC, 0, 16'd7, 0, 0},
      '{ROW_CFG,  dsr_pkg::REG_REL_P, 32'd0, 0, 0, 0},
      '{ROW_BEAT, dsr_pkg::REG_TAU_REC, 0, 16'd7, 0, 0},
      // unmapped indexes must not disturb anything
      '{ROW_CFG,  3'd5, 32'd0, 0, 0, 0},
      '{ROW_CFG,  3'd7, 32'd123, 0, 0, 0},
      '{ROW_BEAT, dsr_pkg::REG_TAU_REC, 0, 16'd9, 0, 0},
      '{ROW_CFG,  dsr_pkg::REG_TAU_REC, 32'hFFFF_FFFF, 0, 0, 0},
      '{ROW_CFG,  dsr_pkg::REG_TAU_INA, 32'hFFFF_FFFF, 0, 0, 0},
      '{ROW_CFG,  dsr_pkg::REG_TAU_FAC, 32'hFFFF_FFFF, 0, 0, 0},
      '{ROW_BEAT, dsr_pkg::REG_TAU_REC, 0, 16'd1, 0, 0}
    };
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_beat(dir_rows[i].volt, dir_rows[i].fixed, dir_rows[i].current);
      end
    end

    // Random part: cycle through the four idle/stall mixes, new settings each phase
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      drain();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      if (phase == 0) begin
        // first phase at defaults-like, well-behaved values
        write_reg(dsr_pkg::REG_TAU_REC, dsr_pkg::TAU_REC_RST);
        write_reg(dsr_pkg::REG_TAU_INA, dsr_pkg::TAU_INA_RST);
        write_reg(dsr_pkg::REG_TAU_FAC, dsr_pkg::TAU_FAC_RST);
        write_reg(dsr_pkg::REG_REL_P, dsr_pkg::REL_P_RST);
        write_reg(dsr_pkg::REG_EFF, dsr_pkg::EFF_RST);
      end else begin
        write_reg(dsr_pkg::REG_TAU_REC, pick_tau());
        write_reg(dsr_pkg::REG_TAU_INA, pick_tau());
        write_reg(dsr_pkg::REG_TAU_FAC, pick_tau());
        case ($urandom_range(3))
          0: write_reg(dsr_pkg::REG_REL_P, 32'd0);
          1: write_reg(dsr_pkg::REG_REL_P, 32'h10000);
          default: write_reg(dsr_pkg::REG_REL_P, $urandom_range(32'h1FFFF));
        endcase
        case ($urandom_range(3))
          0: write_reg(dsr_pkg::REG_EFF, 32'hFFFF_FFFF);
          1: write_reg(dsr_pkg::REG_EFF, $urandom);
          default: write_reg(dsr_pkg::REG_EFF, $urandom_range(32'd65536 * 1000));
        endcase
        if ($urandom_range(3) == 0)
          write_reg(dsr_pkg::IDX_W'($urandom_range(5, 7)), $urandom);
      end
      for (int n = 0; n < BEATS_PER_PH; n++) send_beat(pick_volt(), 1'b0, '0);
    end

    drain();
    if (!fail) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
